### src/chunked_download_receiver_defines.svh
// assertion macros shared by the checker of the chunked download receiver
`ifndef CHUNKED_DOWNLOAD_RECEIVER_DEFINES_SVH
`define CHUNKED_DOWNLOAD_RECEIVER_DEFINES_SVH

// property checked at every clock edge outside reset
`define CDR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("chunked download receiver check failed");

// consequence required in the cycle after the antecedent
`define CDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chunked download receiver sequence check failed");

`endif

### src/cdr_pkg.sv
// types and constants of the chunked download receiver
package cdr_pkg;

  localparam int TIMER_W   = 25;
  localparam int TIMEOUT_W = 24;
  localparam int PLEN_W    = 12;
  localparam int TICK_W    = 20;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd2000000;
  localparam logic [PLEN_W-1:0]    MAX_PAYLOAD   = 12'd2048;

  localparam logic       MODE_PACKET = 1'b0;
  localparam logic       MODE_TICK   = 1'b1;

  localparam logic [1:0] KIND_SET_COUNT   = 2'd0;
  localparam logic [1:0] KIND_FILE_HEADER = 2'd1;
  localparam logic [1:0] KIND_CHUNK       = 2'd2;

  localparam logic [1:0] REPLY_COUNT_ACK  = 2'd0;
  localparam logic [1:0] REPLY_HEADER_ACK = 2'd1;
  localparam logic [1:0] REPLY_CHUNK_ACK  = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [1:0]        packet_kind;
    logic [31:0]       header_value;
    logic [PLEN_W-1:0] payload_length;
    logic              store_ok;
    logic              from_serial;
    logic [TICK_W-1:0] tick_us;
  } item_t;

  typedef struct packed {
    logic        send_reply;
    logic [1:0]  reply_code;
    logic [15:0] reply_chunk;
    logic        session_active;
    logic        file_complete;
    logic [15:0] files_done;
    logic [15:0] files_total;
    logic [31:0] bytes_done;
    logic [31:0] bytes_total;
  } result_t;

  typedef struct packed {
    logic               active;
    logic [TIMER_W-1:0] idle_timer;
    logic [15:0]        expected_chunk;
    logic [31:0]        bytes_total;
    logic [31:0]        bytes_done;
    logic [15:0]        count_total;
    logic [15:0]        count_done;
  } state_t;

endpackage

### src/cdr_in_if.sv
// input channel: decoded packet header or time tick
interface cdr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  packet_kind;
  logic [31:0] header_value;
  logic [11:0] payload_length;
  logic        store_ok;
  logic        from_serial;
  logic [19:0] tick_us;

  modport source (
    output valid, mode, packet_kind, header_value, payload_length, store_ok,
    from_serial, tick_us,
    input  ready
  );
  modport sink (
    input  valid, mode, packet_kind, header_value, payload_length, store_ok,
    from_serial, tick_us,
    output ready
  );
endinterface

### src/cdr_out_if.sv
// result channel: reply request and progress snapshot
interface cdr_out_if;
  logic        valid;
  logic        ready;
  logic        send_reply;
  logic [1:0]  reply_code;
  logic [15:0] reply_chunk;
  logic        session_active;
  logic        file_complete;
  logic [15:0] files_done;
  logic [15:0] files_total;
  logic [31:0] bytes_done;
  logic [31:0] bytes_total;

  modport source (
    output valid, send_reply, reply_code, reply_chunk, session_active,
    file_complete, files_done, files_total, bytes_done, bytes_total,
    input  ready
  );
  modport sink (
    input  valid, send_reply, reply_code, reply_chunk, session_active,
    file_complete, files_done, files_total, bytes_done, bytes_total,
    output ready
  );
endinterface

### src/cdr_update.sv
// next-state and result logic for one item
module cdr_update (
  input  cdr_pkg::item_t                       item,
  input  cdr_pkg::state_t                      state,
  input  logic [cdr_pkg::TIMEOUT_W-1:0]        timeout_us,
  output cdr_pkg::state_t                      state_next,
  output cdr_pkg::result_t                     result
);
  import cdr_pkg::*;

  logic [TIMER_W-1:0] tick_sum;
  logic [15:0]        chunk_num;
  logic [PLEN_W-1:0]  add_len;
  logic [32:0]        byte_sum;
  logic [31:0]        bytes_new;
  logic               send;
  logic [1:0]         code;
  logic [15:0]        echo;
  logic               complete;

  // timer wraps at its own width
  assign tick_sum  = state.idle_timer + TIMER_W'(item.tick_us);
  assign chunk_num = item.header_value[15:0];
  assign add_len   = (item.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : item.payload_length;
  assign byte_sum  = {1'b0, state.bytes_done} + 33'(add_len);
  assign bytes_new = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];

  always_comb begin
    state_next = state;
    send       = 1'b0;
    code       = REPLY_COUNT_ACK;
    echo       = 16'd0;
    complete   = 1'b0;

    if (item.mode == MODE_TICK) begin
      if (state.active) begin
        if (tick_sum >= TIMER_W'(timeout_us)) begin
          state_next.idle_timer = '0;
          state_next.active     = 1'b0;
        end else begin
          state_next.idle_timer = tick_sum;
        end
      end
    end else begin
      case (item.packet_kind)
        KIND_SET_COUNT: begin
          state_next.count_total = item.header_value[15:0];
          state_next.count_done  = 16'd0;
          send                   = !item.from_serial;
          code                   = REPLY_COUNT_ACK;
        end
        KIND_FILE_HEADER: begin
          state_next.bytes_total    = item.header_value;
          state_next.bytes_done     = 32'd0;
          state_next.idle_timer     = '0;
          state_next.expected_chunk = 16'd0;
          state_next.active         = 1'b1;
          send                      = !item.from_serial;
          code                      = REPLY_HEADER_ACK;
        end
        KIND_CHUNK: begin
          if (state.active) begin
            state_next.idle_timer = '0;
            if (chunk_num < state.expected_chunk) begin
              // repeated chunk, acknowledge again
              send = !item.from_serial;
              code = REPLY_CHUNK_ACK;
              echo = chunk_num;
            end else if (chunk_num == state.expected_chunk) begin
              state_next.expected_chunk = state.expected_chunk + 16'd1;
              state_next.bytes_done     = bytes_new;
              if (bytes_new >= state.bytes_total) begin
                state_next.count_done = state.count_done + 16'd1;
                complete              = 1'b1;
              end
              if (item.store_ok && !item.from_serial) begin
                send = 1'b1;
                code = REPLY_CHUNK_ACK;
                echo = chunk_num;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    result.send_reply     = send;
    result.reply_code     = send ? code : REPLY_COUNT_ACK;
    result.reply_chunk    = send ? echo : 16'd0;
    result.session_active = state_next.active;
    result.file_complete  = complete;
    result.files_done     = state_next.count_done;
    result.files_total    = state_next.count_total;
    result.bytes_done     = state_next.bytes_done;
    result.bytes_total    = state_next.bytes_total;
  end
endmodule

### src/chunked_download_receiver.sv
// an accepted item passes through the input register, then the output register, to the outputs
// throughput: one item per cycle while the result side keeps taking transfers
// the session state updates as an item leaves the input register, so the next item sees it
// a stalled result holds in the output register; the input register takes one more transfer
// rst (synchronous, active high) empties both registers, clears all counters, timeout to 2000000
module chunked_download_receiver (
  input  logic                          clk,
  input  logic                          rst,
  cdr_in_if.sink                        in_ch,
  cdr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cdr_pkg::TIMEOUT_W-1:0] cfg_wdata
);
  import cdr_pkg::*;

  // input register
  logic    s1_valid;
  item_t   s1_item;
  item_t   in_item;

  // session state and its update
  state_t  state;
  state_t  state_next;
  result_t result;

  // output register
  logic    out_valid;
  result_t out_data;

  // timeout register
  logic [TIMEOUT_W-1:0] timeout_us;

  logic out_free;
  logic s1_advance;

  // result register can take a new transfer when empty or being drained
  assign out_free   = !out_valid || out_ch.ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;

  assign in_item.mode           = in_ch.mode;
  assign in_item.packet_kind    = in_ch.packet_kind;
  assign in_item.header_value   = in_ch.header_value;
  assign in_item.payload_length = in_ch.payload_length;
  assign in_item.store_ok       = in_ch.store_ok;
  assign in_item.from_serial    = in_ch.from_serial;
  assign in_item.tick_us        = in_ch.tick_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= in_item;
    end
  end

  cdr_update u_update (
    .item       (s1_item),
    .state      (state),
    .timeout_us (timeout_us),
    .state_next (state_next),
    .result     (result)
  );

  // state commits only when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_us <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.send_reply     = out_data.send_reply;
  assign out_ch.reply_code     = out_data.reply_code;
  assign out_ch.reply_chunk    = out_data.reply_chunk;
  assign out_ch.session_active = out_data.session_active;
  assign out_ch.file_complete  = out_data.file_complete;
  assign out_ch.files_done     = out_data.files_done;
  assign out_ch.files_total    = out_data.files_total;
  assign out_ch.bytes_done     = out_data.bytes_done;
  assign out_ch.bytes_total    = out_data.bytes_total;
endmodule

### src/cdr_checker.sv
// port-level checks of the chunked download receiver and their bind
`include "chunked_download_receiver_defines.svh"

module cdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        send_reply,
  input logic [1:0]  reply_code,
  input logic [15:0] reply_chunk,
  input logic        session_active,
  input logic        file_complete,
  input logic [31:0] bytes_done,
  input logic [31:0] bytes_total
);
  import cdr_pkg::*;

  // a stalled result holds
  `CDR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(send_reply) && $stable(reply_chunk) && $stable(bytes_done))

  // no reply means zeroed reply fields
  `CDR_ASSERT(a_quiet_reply, clk, rst, !(out_valid && !send_reply) || (reply_code == REPLY_COUNT_ACK && reply_chunk == 16'd0))

  // completion only on a live session with the byte total reached
  `CDR_ASSERT(a_complete, clk, rst, !(out_valid && file_complete) || (session_active && bytes_done >= bytes_total))

  // an empty result register never blocks the input
  `CDR_ASSERT(a_ready_when_empty, clk, rst, out_valid || in_ready)
endmodule

bind chunked_download_receiver cdr_checker u_cdr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .send_reply     (out_ch.send_reply),
  .reply_code     (out_ch.reply_code),
  .reply_chunk    (out_ch.reply_chunk),
  .session_active (out_ch.session_active),
  .file_complete  (out_ch.file_complete),
  .bytes_done     (out_ch.bytes_done),
  .bytes_total    (out_ch.bytes_total)
);
